FILE: rtl/core/ud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
// ----------------------------------------------------------------------------
package ud_pkg;

    localparam logic        OP_DATA     = 1'b0;
    localparam logic        OP_FLUSH    = 1'b1;

    localparam logic [15:0] UNIT_REPL   = 16'hFFFD;
    localparam logic [15:0] SURR_HI     = 16'hD800;
    localparam logic [15:0] SURR_LO     = 16'hDC00;
    localparam logic [20:0] POINT_MAX   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [16:0] LEAST_2B    = 17'h00080;
    localparam logic [16:0] LEAST_3B    = 17'h00800;
    localparam logic [16:0] LEAST_4B    = 17'h10000;

    // sequence state kept between bytes
    typedef struct packed {
        logic [20:0] partial_point;
        logic [16:0] least_allowed;
        logic [1:0]  bytes_due;
    } seq_state_t;

    // up to two code units produced by one item
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } dec_result_t;

endpackage

FILE: rtl/core/ud_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_decode
// Sequence state register and the single-pass decode of one item into zero,
// one or two UTF-16 code units.
// ----------------------------------------------------------------------------
module ud_decode
    import ud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        operation,
    input  logic [7:0]  byte_value,
    output dec_result_t result
);

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        seq_state_t  st;
    } fresh_t;

    seq_state_t  state_reg;
    seq_state_t  state_next;

    function automatic fresh_t decode_fresh(input logic [7:0] b);
        fresh_t f;
        f = '0;
        priority if (b[7] == 1'b0)
        begin
            f.emit = 1'b1;
            f.unit = {8'h00, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            f.st.partial_point = {16'h0000, b[4:0]};
            f.st.least_allowed = LEAST_2B;
            f.st.bytes_due     = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            f.st.partial_point = {17'h00000, b[3:0]};
            f.st.least_allowed = LEAST_3B;
            f.st.bytes_due     = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            f.st.partial_point = {18'h00000, b[2:0]};
            f.st.least_allowed = LEAST_4B;
            f.st.bytes_due     = 2'd3;
        end
        else
        begin
            f.emit = 1'b1;
            f.unit = UNIT_REPL;
        end
        return f;
    endfunction

    fresh_t      fresh;
    logic [20:0] shifted;
    logic [1:0]  due_dec;
    logic [20:0] offset;
    logic        bad_point;

    always_comb
    begin
        fresh      = decode_fresh(byte_value);
        shifted    = {state_reg.partial_point[14:0], byte_value[5:0]};
        due_dec    = state_reg.bytes_due - 2'd1;
        offset     = shifted - PLANE1_BASE;
        bad_point  = (shifted < {4'h0, state_reg.least_allowed}) ||
                     (shifted > POINT_MAX) ||
                     ((shifted >= SURR_FIRST) && (shifted <= SURR_LAST));
        result     = '0;
        state_next = state_reg;

        priority if (operation == OP_FLUSH)
        begin
            if (state_reg.bytes_due != 2'd0)
            begin
                result.count = 2'd1;
                result.unit0 = UNIT_REPL;
                state_next   = '0;
            end
        end
        else if (state_reg.bytes_due != 2'd0)
        begin
            if (byte_value[7:6] == 2'b10)
            begin
                if (due_dec == 2'd0)
                begin
                    state_next = '0;
                    priority if (bad_point)
                    begin
                        result.count = 2'd1;
                        result.unit0 = UNIT_REPL;
                    end
                    else if (shifted[20:16] == 5'd0)
                    begin
                        result.count = 2'd1;
                        result.unit0 = shifted[15:0];
                    end
                    else
                    begin
                        result.count = 2'd2;
                        result.unit0 = SURR_HI | {6'd0, offset[19:10]};
                        result.unit1 = SURR_LO | {6'd0, offset[9:0]};
                    end
                end
                else
                begin
                    state_next.partial_point = shifted;
                    state_next.bytes_due     = due_dec;
                end
            end
            else
            begin
                // broken sequence, then decode the byte again
                result.unit0 = UNIT_REPL;
                result.unit1 = fresh.unit;
                result.count = fresh.emit ? 2'd2 : 2'd1;
                state_next   = fresh.st;
            end
        end
        else
        begin
            result.count = {1'b0, fresh.emit};
            result.unit0 = fresh.unit;
            state_next   = fresh.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/ud_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_out_buf
// Result register holding up to two code units, drained one per transfer.
// ----------------------------------------------------------------------------
module ud_out_buf
    import ud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dec_result_t result,
    output logic        load_ok,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] code_unit,
    output logic        last
);

    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [15:0] unit0_reg;
    logic [15:0] unit0_next;
    logic [15:0] unit1_reg;
    logic [15:0] unit1_next;
    logic        pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != 2'd0);
    assign last         = (count_reg == 2'd1);
    assign code_unit    = unit0_reg;
    assign load_ok      = (count_reg == 2'd0) || ((count_reg == 2'd1) && result_ready);

    always_comb
    begin
        count_next = count_reg;
        unit0_next = unit0_reg;
        unit1_next = unit1_reg;
        priority if (load)
        begin
            count_next = result.count;
            unit0_next = result.unit0;
            unit1_next = result.unit1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            unit0_next = unit1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit0_reg <= unit0_next;
        unit1_reg <= unit1_next;
    end

endmodule

FILE: rtl/core/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
// The first code unit of an item is offered in the cycle after its transfer.
// Throughput: one byte per cycle while result_ready is high; an item with two code
// units fills the two-entry result register, so the next byte waits for a pop.
// Reset: rst_n clears the sequence state and empties the result register.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to UTF-16 code units, malformed input replaced by U+FFFD.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
    import ud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        operation,
    input  logic [7:0]  byte_value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] code_unit,
    output logic        last
);

    dec_result_t result;
    logic        accept;

    assign accept = item_valid && item_ready;

    ud_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .byte_value (byte_value),
        .result     (result)
    );

    ud_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .result       (result),
        .load_ok      (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_unit    (code_unit),
        .last         (last)
    );

    // no new byte while a first unit of a pair is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> !item_ready)
        else $error("item taken while a unit pair is pending");

    // the first unit of a pair is always followed by the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last) |=> (result_valid && last))
        else $error("second unit of a pair missing");

    // a transfer that yields units shows its first unit next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.count != 2'd0) |=>
            (result_valid && code_unit == $past(result.unit0)))
        else $error("first code unit not presented");

    // a transfer that yields nothing leaves the result register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.count == 2'd0) |=> !result_valid)
        else $error("result shown for an item without output");

endmodule

FILE: bench/utf8_to_utf16_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_test
// Drives UTF-8 bytes and flushes into the decoder and checks every UTF-16
// code unit against a cycle-free model of the decoder kept in this bench.
// Directed cases cover the code point extremes, rejected values, bad leads,
// broken sequences and flushes. Random streams of mostly well-formed sequences
// follow, first back to back, then with random idling on both sides.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_test;
    import ud_pkg::*;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } unit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        operation = OP_DATA;
    logic [7:0]  byte_value = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [15:0] code_unit;
    logic        last;

    // decoder state mirrored by the bench
    logic [20:0] seq_point = '0;
    logic [16:0] seq_least = '0;
    logic [1:0]  seq_due = '0;

    logic [15:0] item_units[$];
    unit_t       expected_units[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          sender_steady = 1'b0;
    bit          receiver_steady = 1'b0;

    utf8_to_utf16_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .byte_value   (byte_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_unit    (code_unit),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ready <= receiver_steady || ($urandom_range(99) >= 23);
    end

    function automatic void clear_sequence();
        seq_point = '0;
        seq_least = '0;
        seq_due   = '0;
    endfunction

    // one more code unit for the current item
    function automatic void add_unit(input logic [15:0] u);
        item_units = {item_units, u};
    endfunction

    // byte seen with no sequence open
    function automatic void decode_lead(input logic [7:0] b);
        casez (b)
            8'b0???????:
            begin
                add_unit({8'h00, b});
            end
            8'b110?????:
            begin
                seq_point = {16'h0, b[4:0]};
                seq_least = LEAST_2B;
                seq_due   = 2'd1;
            end
            8'b1110????:
            begin
                seq_point = {17'h0, b[3:0]};
                seq_least = LEAST_3B;
                seq_due   = 2'd2;
            end
            8'b11110???:
            begin
                seq_point = {18'h0, b[2:0]};
                seq_least = LEAST_4B;
                seq_due   = 2'd3;
            end
            default:
            begin
                add_unit(UNIT_REPL);
            end
        endcase
    endfunction

    task automatic predict_units(input logic op, input logic [7:0] b);
        logic [20:0] point;
        logic [16:0] least;
        unit_t       entry;
        item_units.delete();
        if (op == OP_FLUSH)
        begin
            if (seq_due != 2'd0)
            begin
                add_unit(UNIT_REPL);
                clear_sequence();
            end
        end
        else if (seq_due != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                seq_point = {seq_point[14:0], b[5:0]};
                seq_due   = seq_due - 2'd1;
                if (seq_due == 2'd0)
                begin
                    point = seq_point;
                    least = seq_least;
                    clear_sequence();
                    if (point < {4'h0, least} || point > POINT_MAX ||
                        (point >= SURR_FIRST && point <= SURR_LAST))
                        add_unit(UNIT_REPL);
                    else if (point < PLANE1_BASE)
                        add_unit(point[15:0]);
                    else
                    begin
                        point = point - PLANE1_BASE;
                        add_unit(SURR_HI + {6'h0, point[19:10]});
                        add_unit(SURR_LO + {6'h0, point[9:0]});
                    end
                end
            end
            else
            begin
                add_unit(UNIT_REPL);
                clear_sequence();
                decode_lead(b);
            end
        end
        else
            decode_lead(b);
        foreach (item_units[i])
        begin
            entry.unit     = item_units[i];
            entry.last     = (i == item_units.size() - 1);
            expected_units = {expected_units, entry};
        end
    endtask

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        unit_t exp_unit;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                predict_units(operation, byte_value);
            if (result_valid && result_ready)
            begin
                if (expected_units.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected code unit %h last %0d", code_unit, last);
                end
                else
                begin
                    exp_unit = expected_units.pop_front();
                    if (code_unit !== exp_unit.unit || last !== exp_unit.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("code unit error: expected %h last %0d, got %h last %0d",
                                     exp_unit.unit, exp_unit.last, code_unit, last);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        if (!sender_steady && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        byte_value <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_item(OP_DATA, seq[i]);
    endtask

    task automatic test_single_units();
        send_bytes('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF});
    endtask

    task automatic test_code_point_extremes();
        send_bytes('{8'hC2, 8'h80, 8'hDF, 8'hBF});
        send_bytes('{8'hEF, 8'hBF, 8'hBF});
        send_bytes('{8'hF0, 8'h90, 8'h80, 8'h80});
        send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    endtask

    task automatic test_rejected_values();
        send_bytes('{8'hC0, 8'h80, 8'hE0, 8'h9F, 8'hBF});
        send_bytes('{8'hED, 8'hA0, 8'h80});
        send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    endtask

    task automatic test_broken_sequences();
        send_bytes('{8'hE2, 8'h82, 8'h41, 8'hC3, 8'hFF, 8'hF0, 8'hC3, 8'hA9});
    endtask

    task automatic test_flush();
        send_item(OP_FLUSH, 8'hFF);
        send_item(OP_DATA, 8'hF0);
        send_item(OP_DATA, 8'h9F);
        send_item(OP_FLUSH, 8'h00);
    endtask

    // mostly well-formed sequences with random content, some truncated
    task automatic send_random_streams(input int item_total);
        int          kind;
        int          len;
        int          cont_count;
        logic [7:0]  lead;
        int          stop_at;
        stop_at = items_sent + item_total;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: lead = {1'b0, 7'($urandom)};
                    2: lead = {3'b110, 5'($urandom)};
                    3: lead = {4'b1110, 4'($urandom)};
                    default: lead = {5'b11110, 3'($urandom)};
                endcase
                cont_count = len - 1;
                if (kind >= 60 && len > 1)
                    cont_count = $urandom_range(0, len - 2);
                send_item(OP_DATA, lead);
                repeat (cont_count)
                    send_item(OP_DATA, {2'b10, 6'($urandom)});
            end
            else if (kind < 85)
                send_item(OP_FLUSH, 8'($urandom));
            else
                send_item(OP_DATA, 8'($urandom));
        end
    endtask

    task automatic test_back_to_back();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        send_random_streams(300);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        send_random_streams(1600);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_single_units();
        test_code_point_extremes();
        test_rejected_values();
        test_broken_sequences();
        test_flush();
        test_back_to_back();
        test_random_traffic();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ud_pkg.sv
rtl/core/ud_decode.sv
rtl/core/ud_out_buf.sv
rtl/core/utf8_to_utf16_decoder.sv
bench/utf8_to_utf16_decoder_test.sv
